### rtl/cfs_pkg.sv
// Shared types and constants for the catapult feed sequencer.
`default_nettype none

package cfs_pkg;

    localparam logic [2:0] PH_REST     = 3'd0;
    localparam logic [2:0] PH_COCKING  = 3'd1;
    localparam logic [2:0] PH_HELD     = 3'd2;
    localparam logic [2:0] PH_FIRING   = 3'd3;
    localparam logic [2:0] PH_OVERRIDE = 3'd4;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_FEED   = 2'd1;
    localparam logic [1:0] MODE_FIRE   = 2'd2;

    localparam logic [7:0] FULL_FWD = 8'h7F;  // +127
    localparam logic [7:0] FULL_REV = 8'h81;  // -127
    localparam logic [7:0] DRIVE_OFF = 8'h00;

    localparam logic [1:0] CFG_FIRE_DURATION = 2'd0;
    localparam logic [1:0] CFG_FIRE_DELAY    = 2'd1;
    localparam logic [1:0] CFG_HOLD_SPEED    = 2'd2;

    localparam logic [15:0] FIRE_DURATION_RST = 16'd750;
    localparam logic [15:0] FIRE_DELAY_RST    = 16'd500;
    localparam logic [7:0]  HOLD_SPEED_RST    = 8'd15;

    // button bit positions
    localparam int BTN_FIRE      = 0;
    localparam int BTN_OVERRIDE  = 1;
    localparam int BTN_REVERSE   = 2;
    localparam int BTN_FEED_FWD  = 3;
    localparam int BTN_FEED_REV  = 4;
    localparam int BTN_LATCH     = 5;
    localparam int BTN_CANCEL    = 6;
    localparam int BTN_AUTOFIRE  = 7;
    localparam int BTN_AUTOFEED  = 8;
    localparam int BTN_STOP_A    = 9;
    localparam int BTN_STOP_B    = 10;

    typedef struct packed {
        logic [15:0] fire_duration;
        logic [15:0] fire_delay;
        logic [7:0]  hold_speed;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  mode;
        logic        latched_feed;
        logic        ball_seen;
        logic [15:0] fire_timer;
        logic [15:0] top_timer;
        logic [7:0]  catapult_level;
        logic [7:0]  feed_level;
    } state_t;

    typedef struct packed {
        logic [7:0] catapult_drive;
        logic [7:0] feed_drive;
        logic [2:0] catapult_phase;
        logic [1:0] active_mode;
    } result_t;

endpackage

`default_nettype wire

### rtl/cfs_tick.sv
// Next-state logic for one control-loop tick.
`default_nettype none

module cfs_tick (
    input  cfs_pkg::state_t cur,
    input  cfs_pkg::cfg_t   cfg,
    input  logic [10:0]     buttons,
    input  logic            catapult_switch,
    input  logic            feed_switch,
    input  logic [7:0]      elapsed_ms,
    output cfs_pkg::state_t nxt
);
    import cfs_pkg::*;

    logic [16:0] fire_sum;
    logic [16:0] top_sum;
    logic [15:0] ft;
    logic [15:0] tt;

    assign fire_sum = {1'b0, cur.fire_timer} + {9'd0, elapsed_ms};
    assign top_sum  = {1'b0, cur.top_timer} + {9'd0, elapsed_ms};
    assign ft = fire_sum[16] ? 16'hFFFF : fire_sum[15:0];
    assign tt = top_sum[16] ? 16'hFFFF : top_sum[15:0];

    always_comb
    begin
        nxt = cur;
        nxt.fire_timer = ft;
        nxt.top_timer  = tt;

        unique case (cur.mode)
            MODE_MANUAL:
            begin
                // most ticks take none of these transitions
                if (cur.phase == PH_REST && buttons[BTN_FIRE])
                begin
                    nxt.phase = PH_COCKING;
                    nxt.catapult_level = FULL_FWD;
                end
                else if (cur.phase == PH_COCKING && !catapult_switch)
                begin
                    nxt.phase = PH_HELD;
                    nxt.catapult_level = cfg.hold_speed;
                end
                else if (cur.phase == PH_HELD && buttons[BTN_FIRE])
                begin
                    nxt.phase = PH_FIRING;
                    nxt.fire_timer = 16'd0;
                    nxt.catapult_level = FULL_FWD;
                end
                else if (cur.phase == PH_FIRING && ft > cfg.fire_duration)
                begin
                    nxt.phase = PH_REST;
                    nxt.catapult_level = DRIVE_OFF;
                end
                else if (cur.phase == PH_OVERRIDE && !buttons[BTN_OVERRIDE])
                begin
                    nxt.phase = PH_HELD;
                    nxt.catapult_level = cfg.hold_speed;
                end
                if (buttons[BTN_OVERRIDE])
                begin
                    nxt.phase = PH_OVERRIDE;
                    nxt.catapult_level = buttons[BTN_REVERSE] ? FULL_REV : FULL_FWD;
                end

                if (!cur.latched_feed)
                begin
                    priority if (buttons[BTN_FEED_FWD])
                        nxt.feed_level = FULL_FWD;
                    else if (buttons[BTN_FEED_REV])
                        nxt.feed_level = FULL_REV;
                    else if (buttons[BTN_LATCH])
                    begin
                        nxt.latched_feed = 1'b1;
                        nxt.feed_level = FULL_FWD;
                    end
                    else
                        nxt.feed_level = DRIVE_OFF;
                end
                else if (buttons[BTN_CANCEL] || buttons[BTN_FEED_FWD]
                         || buttons[BTN_FEED_REV])
                begin
                    nxt.latched_feed = 1'b0;
                end

                if (buttons[BTN_AUTOFIRE])
                    nxt.mode = MODE_FIRE;
                else if (buttons[BTN_AUTOFEED])
                    nxt.mode = MODE_FEED;
            end
            MODE_FIRE:
            begin
                nxt.feed_level = (!feed_switch && catapult_switch) ? DRIVE_OFF : FULL_FWD;
                if (!feed_switch)
                begin
                    nxt.top_timer = 16'd0;
                    nxt.ball_seen = 1'b1;
                end
                // top_timer is only compared when the ball is not at the top
                priority if (catapult_switch)
                    nxt.catapult_level = FULL_FWD;
                else if (feed_switch && tt > cfg.fire_delay && cur.ball_seen)
                begin
                    nxt.feed_level = DRIVE_OFF;
                    nxt.catapult_level = FULL_FWD;
                    nxt.phase = PH_FIRING;
                    nxt.mode = MODE_MANUAL;
                    nxt.ball_seen = 1'b0;
                    nxt.fire_timer = 16'd0;
                end
                else
                    nxt.catapult_level = cfg.hold_speed;
            end
            default:
            begin
                // auto feed to top; unknown codes behave the same
                if (feed_switch)
                    nxt.feed_level = FULL_FWD;
                else
                begin
                    nxt.feed_level = DRIVE_OFF;
                    nxt.mode = MODE_MANUAL;
                end
            end
        endcase

        if (buttons[BTN_STOP_A] && buttons[BTN_STOP_B])
        begin
            nxt.catapult_level = cfg.hold_speed;
            nxt.feed_level = DRIVE_OFF;
            nxt.mode = MODE_MANUAL;
            nxt.phase = PH_HELD;
        end
    end

endmodule

`default_nettype wire

### rtl/cfs_out_buf.sv
// Two-entry result buffer between the tick logic and the output channel.
`default_nettype none

module cfs_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cfs_pkg::result_t push_data,
    output logic             full,
    output logic             out_valid,
    input  logic             out_stall,
    output cfs_pkg::result_t head
);
    import cfs_pkg::*;

    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = out_valid && !out_stall;
    assign head      = slot0_reg;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = push_data;
                else
                    slot1_next = push_data;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                    slot0_next = push_data;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full result buffer");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && count_reg == 2'd1) |=> full)
        else $error("result buffer count lost a request");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(head)))
        else $error("stalled head changed");

endmodule

`default_nettype wire

### rtl/catapult_feed_sequencer.sv
// Top level of the catapult feed sequencer: state, config and output buffer.
// A request's result is registered into the output buffer at the edge that accepts it.
// Throughput: one request per cycle unless in_stall; the tick logic is a single combinational pass.
// A two-entry result buffer keeps input flowing while a result waits; input stalls
// only when both entries are held. Reset (rst_n low, async) clears all state,
// empties the buffer and loads the config registers with their default values.
`default_nettype none

module catapult_feed_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [10:0]       buttons,
    input  logic              catapult_switch,
    input  logic              feed_switch,
    input  logic [7:0]        elapsed_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [7:0] catapult_drive,
    output logic signed [7:0] feed_drive,
    output logic [2:0]        catapult_phase,
    output logic [1:0]        active_mode
);
    import cfs_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res;
    result_t head;
    logic    buf_full;
    logic    in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fire_duration <= FIRE_DURATION_RST;
            cfg_reg.fire_delay    <= FIRE_DELAY_RST;
            cfg_reg.hold_speed    <= HOLD_SPEED_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIRE_DURATION: cfg_reg.fire_duration <= cfg_data;
                CFG_FIRE_DELAY:    cfg_reg.fire_delay    <= cfg_data;
                CFG_HOLD_SPEED:    cfg_reg.hold_speed    <= cfg_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    cfs_tick u_tick (
        .cur             (state_reg),
        .cfg             (cfg_reg),
        .buttons         (buttons),
        .catapult_switch (catapult_switch),
        .feed_switch     (feed_switch),
        .elapsed_ms      (elapsed_ms),
        .nxt             (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PH_REST;
            state_reg.mode           <= MODE_MANUAL;
            state_reg.latched_feed   <= 1'b0;
            state_reg.ball_seen      <= 1'b0;
            state_reg.fire_timer     <= 16'd0;
            state_reg.top_timer      <= 16'd0;
            state_reg.catapult_level <= DRIVE_OFF;
            state_reg.feed_level     <= DRIVE_OFF;
        end
        else if (in_accept)
            state_reg <= state_next;
    end

    assign res.catapult_drive = state_next.catapult_level;
    assign res.feed_drive     = state_next.feed_level;
    assign res.catapult_phase = state_next.phase;
    assign res.active_mode    = state_next.mode;

    cfs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign catapult_drive = $signed(head.catapult_drive);
    assign feed_drive     = $signed(head.feed_drive);
    assign catapult_phase = head.catapult_phase;
    assign active_mode    = head.active_mode;

    a_stop_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && buttons[BTN_STOP_A] && buttons[BTN_STOP_B])
        |=> (state_reg.phase == PH_HELD && state_reg.mode == MODE_MANUAL
             && state_reg.feed_level == DRIVE_OFF))
        else $error("stop pair did not force held/manual");

    a_timer_sat: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg.top_timer >= $past(state_reg.top_timer)
                       || state_reg.top_timer == 16'd0))
        else $error("top timer wrapped");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(state_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire
